FILE: sv/pca_pkg.sv
// Shared types, constants and arithmetic helpers for the pixel color adjust block.
package pca_pkg;

	localparam int NUM_STAGES = 7;

	localparam logic [11:0] LUMA_R = 12'd819;
	localparam logic [11:0] LUMA_G = 12'd2867;
	localparam logic [11:0] LUMA_B = 12'd410;

	localparam logic [12:0] Q_ONE = 13'd4096;

	typedef enum logic [2:0] {
		REG_SATURATION_GAIN   = 3'd0,
		REG_EXPOSURE_GAIN     = 3'd1,
		REG_CONTRAST_GAIN     = 3'd2,
		REG_BRIGHTNESS_OFFSET = 3'd3,
		REG_LEVEL_LOW         = 3'd4,
		REG_LEVEL_SPAN_RECIP  = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic signed [15:0] saturation_gain;
		logic signed [15:0] exposure_gain;
		logic signed [15:0] contrast_gain;
		logic signed [15:0] brightness_offset;
		logic signed [15:0] level_low;
		logic signed [15:0] level_span_recip;
	} gains_t;

	// Load enables of the pipeline registers, one per stage.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} adv_t;

	// 8-bit channel to Q4.12: floor((c*4096 + 127) / 255).
	// c*4096 = 255*16c + 16c, so only floor((16c + 127) / 255) is left,
	// done as a multiply by 257 with the +1 correction.
	function automatic logic [12:0] to_q12(input logic [7:0] c);
		logic [12:0] m1;
		logic [21:0] prod;
		m1 = {1'b0, c, 4'b0000} + 13'd128;
		prod = 22'(m1) * 22'd257;
		return {1'b0, c, 4'b0000} + {7'b0, prod[21:16]};
	endfunction

	// floor((p + 2048) / 4096) of a product whose magnitude stays within 2^30.
	function automatic logic signed [19:0] q_round(input logic signed [31:0] p);
		logic signed [32:0] t;
		t = {p[31], p} + 33'sd2048;
		return t[31:12];
	endfunction

	// Saturate to the Q4.12 range.
	function automatic logic signed [15:0] sat_q(input logic signed [21:0] v);
		logic signed [15:0] r;
		if (v > 22'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -22'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

FILE: sv/pca_front.sv
// Front stages: channel conversion to Q4.12 and luma.
module pca_front (
	input  logic                clk,
	input  pca_pkg::adv_t       adv,
	input  logic [7:0]          in_red,
	input  logic [7:0]          in_green,
	input  logic [7:0]          in_blue,
	output logic [12:0]         x_red,
	output logic [12:0]         x_green,
	output logic [12:0]         x_blue,
	output logic [12:0]         luma
);

	logic [12:0] xr_s1, xg_s1, xb_s1;
	logic [12:0] xr_s2, xg_s2, xb_s2;
	logic [12:0] luma_s2;
	logic [24:0] luma_sum;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			xr_s1 <= pca_pkg::to_q12(in_red);
			xg_s1 <= pca_pkg::to_q12(in_green);
			xb_s1 <= pca_pkg::to_q12(in_blue);
		end
	end

	always_comb begin
		luma_sum = 25'(xr_s1) * 25'(pca_pkg::LUMA_R)
			+ 25'(xg_s1) * 25'(pca_pkg::LUMA_G)
			+ 25'(xb_s1) * 25'(pca_pkg::LUMA_B)
			+ 25'd2048;
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			xr_s2   <= xr_s1;
			xg_s2   <= xg_s1;
			xb_s2   <= xb_s1;
			luma_s2 <= luma_sum[24:12];
		end
	end

	assign x_red   = xr_s2;
	assign x_green = xg_s2;
	assign x_blue  = xb_s2;
	assign luma    = luma_s2;

endmodule

FILE: sv/pca_chan.sv
// Per-channel gain chain: saturation, exposure, contrast, offsets, span and output scaling.
module pca_chan (
	input  logic             clk,
	input  pca_pkg::adv_t    adv,
	input  pca_pkg::gains_t  gains,
	input  logic [12:0]      x,
	input  logic [12:0]      luma,
	output logic [7:0]       chan
);

	logic signed [31:0] p_s3;
	logic [12:0]        luma_s3;
	logic signed [31:0] p_s4;
	logic signed [31:0] p_s5;
	logic signed [31:0] p_s6;
	logic [7:0]         chan_s7;

	logic signed [13:0] diff;
	logic signed [15:0] s_val, t1, t2, t3, y;
	logic [12:0]        y_clamp;
	logic [20:0]        y_scaled;

	// Stage 3: distance from luma times saturation gain.
	always_comb begin
		diff = $signed({1'b0, x}) - $signed({1'b0, luma});
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			p_s3    <= 32'(diff) * 32'(gains.saturation_gain);
			luma_s3 <= luma;
		end
	end

	// Stage 4: add luma back, then exposure gain.
	always_comb begin
		s_val = pca_pkg::sat_q($signed({9'b0, luma_s3}) + 22'(pca_pkg::q_round(p_s3)));
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			p_s4 <= 32'(s_val) * 32'(gains.exposure_gain);
		end
	end

	// Stage 5: contrast gain.
	always_comb begin
		t1 = pca_pkg::sat_q(22'(pca_pkg::q_round(p_s4)));
	end

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			p_s5 <= 32'(t1) * 32'(gains.contrast_gain);
		end
	end

	// Stage 6: brightness and black level, then span reciprocal.
	always_comb begin
		t2 = pca_pkg::sat_q(22'(pca_pkg::q_round(p_s5)));
		t3 = pca_pkg::sat_q(22'(t2) + 22'(gains.brightness_offset) - 22'(gains.level_low));
	end

	always_ff @(posedge clk) begin
		if (adv.s6) begin
			p_s6 <= 32'(t3) * 32'(gains.level_span_recip);
		end
	end

	// Stage 7: clamp to 0..1 and truncate to 8 bits.
	always_comb begin
		y = pca_pkg::sat_q(22'(pca_pkg::q_round(p_s6)));
		if (y[15]) begin
			y_clamp = '0;
		end else if (y > $signed({3'b000, pca_pkg::Q_ONE})) begin
			y_clamp = pca_pkg::Q_ONE;
		end else begin
			y_clamp = y[12:0];
		end
		y_scaled = {y_clamp, 8'b0} - 21'(y_clamp);
	end

	always_ff @(posedge clk) begin
		if (adv.s7) begin
			chan_s7 <= y_scaled[19:12];
		end
	end

	assign chan = chan_s7;

endmodule

FILE: sv/pca_pkg_top_placeholder_unused.sv
// Stage valid tracking and hold logic for the pixel color adjust pipeline.
module pca_ctrl (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 out_stall,
	output logic                                 in_stall,
	output logic                                 out_valid,
	output pca_pkg::adv_t                        adv
);

	logic [pca_pkg::NUM_STAGES:1]   valid_q;
	logic [pca_pkg::NUM_STAGES+1:1] rdy;
	logic [pca_pkg::NUM_STAGES:0]   vin;

	// A stage takes a new item when it is empty or its item moves on.
	always_comb begin
		rdy[pca_pkg::NUM_STAGES+1] = !out_stall;
		for (int k = pca_pkg::NUM_STAGES; k >= 1; k--) begin
			rdy[k] = !valid_q[k] || rdy[k+1];
		end
		vin = {valid_q, in_valid};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int k = 1; k <= pca_pkg::NUM_STAGES; k++) begin
				if (rdy[k]) begin
					valid_q[k] <= vin[k-1];
				end
			end
		end
	end

	assign adv.s1    = rdy[1];
	assign adv.s2    = rdy[2];
	assign adv.s3    = rdy[3];
	assign adv.s4    = rdy[4];
	assign adv.s5    = rdy[5];
	assign adv.s6    = rdy[6];
	assign adv.s7    = rdy[7];
	assign in_stall  = !rdy[1];
	assign out_valid = valid_q[pca_pkg::NUM_STAGES];

endmodule

FILE: sv/pixel_color_adjust.sv
// Top level of the pixel color adjust block: registers, control and datapath.
//
//  channel | signals                                   | moves
//  --------+-------------------------------------------+-----------------------------
//  in      | in_valid, in_stall, in_red/green/blue     | one RGB pixel item
//  out     | out_valid, out_stall, out_red/green/blue  | one adjusted RGB pixel item
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | one register write
//
// One item per clock while in_stall is low; each item passes through the stages:
// conversion, luma, one multiply stage per gain (four) and the output clamp stage.
// Reset empties the pipeline and loads the default gains; cfg_ready is always high.
// An empty stage takes a new item even while the output is held, so bubbles
// close up; in_stall rises only when every stage holds an item and out_stall is high.
module pixel_color_adjust (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_red,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_blue,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	pca_pkg::gains_t gains_q;
	pca_pkg::adv_t   adv;
	logic [12:0]     x_red, x_green, x_blue, luma;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.saturation_gain   <= 16'sd5734;
			gains_q.exposure_gain     <= 16'sd5793;
			gains_q.contrast_gain     <= 16'sd3277;
			gains_q.brightness_offset <= -16'sd410;
			gains_q.level_low         <= -16'sd410;
			gains_q.level_span_recip  <= 16'sd3413;
		end else if (cfg_valid && cfg_ready) begin
			case (pca_pkg::cfg_index_t'(cfg_index))
				pca_pkg::REG_SATURATION_GAIN: begin
					gains_q.saturation_gain <= cfg_data;
				end
				pca_pkg::REG_EXPOSURE_GAIN: begin
					gains_q.exposure_gain <= cfg_data;
				end
				pca_pkg::REG_CONTRAST_GAIN: begin
					gains_q.contrast_gain <= cfg_data;
				end
				pca_pkg::REG_BRIGHTNESS_OFFSET: begin
					gains_q.brightness_offset <= cfg_data;
				end
				pca_pkg::REG_LEVEL_LOW: begin
					gains_q.level_low <= cfg_data;
				end
				pca_pkg::REG_LEVEL_SPAN_RECIP: begin
					gains_q.level_span_recip <= cfg_data;
				end
				default: begin
					// drop writes to unused indexes
				end
			endcase
		end
	end

	pca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.adv       (adv)
	);

	pca_front u_front (
		.clk      (clk),
		.adv      (adv),
		.in_red   (in_red),
		.in_green (in_green),
		.in_blue  (in_blue),
		.x_red    (x_red),
		.x_green  (x_green),
		.x_blue   (x_blue),
		.luma     (luma)
	);

	pca_chan u_chan_red (
		.clk   (clk),
		.adv   (adv),
		.gains (gains_q),
		.x     (x_red),
		.luma  (luma),
		.chan  (out_red)
	);

	pca_chan u_chan_green (
		.clk   (clk),
		.adv   (adv),
		.gains (gains_q),
		.x     (x_green),
		.luma  (luma),
		.chan  (out_green)
	);

	pca_chan u_chan_blue (
		.clk   (clk),
		.adv   (adv),
		.gains (gains_q),
		.x     (x_blue),
		.luma  (luma),
		.chan  (out_blue)
	);

endmodule
